[rtl/mda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_pkg: shared definitions for the mouse delta accumulator
// Action codes, entry layout, limits and the saturating helpers.
// ----------------------------------------------------------------------------
package mda_pkg;

  localparam int MOUSE_COUNT_DEF = 16;

  localparam int ACT_W   = 3;
  localparam int IDX_W   = 4;
  localparam int DELTA_W = 12;
  localparam int ACC_W   = 13;
  localparam int BTN_W   = 8;
  localparam int REP_W   = 8;

  localparam logic [ACT_W-1:0] ACT_MOVE_BTN = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EDIT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_OPEN     = 3'd4;

  localparam logic signed [ACC_W:0]   ACC_LIMIT    = 14'sd2048;
  localparam logic signed [ACC_W-1:0] REPORT_LIMIT = 13'sd127;
  localparam logic [BTN_W-1:0]        HEADER_MARK  = 8'h80;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic [BTN_W-1:0]        btn;
    logic                    pend;
  } entry_t;

  // accumulator plus delta, saturated at +-2048
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]   acc,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [ACC_W:0] sum;
    sum = (ACC_W+1)'(acc) + (ACC_W+1)'(d);
    if (sum > ACC_LIMIT) begin
      sat_add = ACC_W'(ACC_LIMIT);
    end else if (sum < -ACC_LIMIT) begin
      sat_add = ACC_W'(-ACC_LIMIT);
    end else begin
      sat_add = sum[ACC_W-1:0];
    end
  endfunction

  // report amount: accumulator clamped to +-127
  function automatic logic signed [REP_W-1:0] clamp_rep(
    input logic signed [ACC_W-1:0] acc
  );
    if (acc > REPORT_LIMIT) begin
      clamp_rep = REP_W'(REPORT_LIMIT);
    end else if (acc < -REPORT_LIMIT) begin
      clamp_rep = REP_W'(-REPORT_LIMIT);
    end else begin
      clamp_rep = acc[REP_W-1:0];
    end
  endfunction

endpackage

[rtl/mda_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_ram: generic single-clock RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module mda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mouse_delta_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_delta_accumulator: per-mouse motion accumulators with report reads
// Moves, button edits, reads and opens on a table of mouse entries.
// ----------------------------------------------------------------------------
// The entry is read from the state RAM when a word is accepted, then
// modified and written back from the s1 registers as the output
// register loads; that waits while the output stalls. Words are accepted
// every cycle unless the output stalls; a write that lands in the same
// cycle as the read of the next word for the same mouse is forwarded. The
// state RAM has no reset sweep: a valid bit per entry, cleared by reset,
// makes unwritten entries read as zero: usable from the first cycle after reset.
module mouse_delta_accumulator #(
  parameter int MOUSE_COUNT = mda_pkg::MOUSE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: init_buttons
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] mouse_index, [15:4] delta_x, [27:16] delta_y, [35:28] new_buttons,
  // [43:36] clear_mask, [51:44] toggle_mask, [55:52] zero
  input  logic [55:0] in_tdata,
  // [2:0] action
  input  logic [2:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] header_byte, [15:8] report_x, [23:16] report_y,
  // [24] pending_after, [25] changed, [31:26] zero
  output logic [31:0] out_tdata,
  // [0] status
  output logic        out_tuser
);
  import mda_pkg::*;

  localparam int AW = (MOUSE_COUNT > 1) ? $clog2(MOUSE_COUNT) : 1;
  localparam int EW = $bits(entry_t);

  logic [BTN_W-1:0] init_btn_r;

  logic [MOUSE_COUNT-1:0] vld_r;

  logic               s1_vld_r;
  logic [ACT_W-1:0]   s1_act_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic signed [DELTA_W-1:0] s1_dx_r, s1_dy_r;
  logic [BTN_W-1:0]   s1_nb_r, s1_clr_r, s1_tog_r;
  logic               s1_fwd_r;
  entry_t             s1_fwd_data_r;
  logic               s1_ent_vld_r;

  logic               out_vld_r;
  logic               out_status_r;
  logic [BTN_W-1:0]   out_hdr_r;
  logic [REP_W-1:0]   out_rx_r, out_ry_r;
  logic               out_pend_r, out_chg_r;

  logic               in_acc, s1_adv;
  logic [AW-1:0]      in_addr, s1_addr;
  logic               in_range;
  logic [EW-1:0]      rd_raw;
  entry_t             cur, nxt_ent;
  logic               wr_en;

  logic               status_nxt, pend_nxt, chg_nxt, change;
  logic [BTN_W-1:0]   hdr_nxt, b_new;
  logic signed [REP_W-1:0] cx, cy;
  logic signed [ACC_W-1:0] rx_left, ry_left;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign in_addr   = AW'(in_tdata[IDX_W-1:0]);
  assign s1_addr   = AW'(s1_idx_r);
  assign in_range  = {{(32-IDX_W){1'b0}}, s1_idx_r} < 32'(MOUSE_COUNT);

  mda_ram #(
    .WIDTH (EW),
    .DEPTH (MOUSE_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (nxt_ent),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (rd_raw)
  );

  always_comb begin
    if (s1_fwd_r) begin
      cur = s1_fwd_data_r;
    end else if (s1_ent_vld_r) begin
      cur = entry_t'(rd_raw);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    cx      = clamp_rep(cur.x);
    cy      = clamp_rep(cur.y);
    rx_left = cur.x - ACC_W'(cx);
    ry_left = cur.y - ACC_W'(cy);
    b_new   = cur.btn;
    change  = 1'b0;
    nxt_ent = cur;
    wr_en   = 1'b0;
    status_nxt = STATUS_OK;
    hdr_nxt = '0;
    pend_nxt = 1'b0;
    chg_nxt = 1'b0;
    if (!in_range) begin
      status_nxt = (s1_act_r == ACT_READ) ? STATUS_NOT_READY : STATUS_OK;
    end else begin
      pend_nxt = cur.pend;
      unique case (s1_act_r)
        ACT_MOVE_BTN, ACT_MOVE, ACT_EDIT: begin
          if (s1_act_r == ACT_MOVE_BTN) begin
            b_new = s1_nb_r;
          end else if (s1_act_r == ACT_EDIT) begin
            b_new = (cur.btn & ~s1_clr_r) ^ s1_tog_r;
          end
          if (s1_act_r == ACT_EDIT) begin
            change = (b_new != cur.btn);
            nxt_ent.x = cur.x;
            nxt_ent.y = cur.y;
          end else begin
            change = (s1_dx_r != '0) || (s1_dy_r != '0) || (b_new != cur.btn);
            nxt_ent.x = sat_add(cur.x, s1_dx_r);
            nxt_ent.y = sat_add(cur.y, s1_dy_r);
          end
          nxt_ent.btn  = b_new;
          nxt_ent.pend = 1'b1;
          if (change) begin
            wr_en    = s1_adv;
            pend_nxt = 1'b1;
            chg_nxt  = 1'b1;
          end
        end
        ACT_READ: begin
          if (!cur.pend) begin
            status_nxt = STATUS_NOT_READY;
          end else begin
            nxt_ent.x    = rx_left;
            nxt_ent.y    = ry_left;
            nxt_ent.pend = (rx_left != '0) || (ry_left != '0);
            wr_en        = s1_adv;
            pend_nxt     = nxt_ent.pend;
            hdr_nxt      = cur.btn | HEADER_MARK;
          end
        end
        ACT_OPEN: begin
          nxt_ent.x    = '0;
          nxt_ent.y    = '0;
          nxt_ent.btn  = init_btn_r;
          nxt_ent.pend = 1'b0;
          wr_en        = s1_adv;
          pend_nxt     = 1'b0;
        end
        default: begin
          // unused codes leave the entry alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_btn_r <= '0;
      vld_r      <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_btn_r <= cfg_wdata;
      end
      if (wr_en) begin
        vld_r[s1_addr] <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r      <= in_tuser;
      s1_idx_r      <= in_tdata[3:0];
      s1_dx_r       <= in_tdata[15:4];
      s1_dy_r       <= in_tdata[27:16];
      s1_nb_r       <= in_tdata[35:28];
      s1_clr_r      <= in_tdata[43:36];
      s1_tog_r      <= in_tdata[51:44];
      // write landing on the same edge as this read: RAM data is stale
      s1_fwd_r      <= wr_en && (s1_addr == in_addr);
      s1_fwd_data_r <= nxt_ent;
      s1_ent_vld_r  <= vld_r[in_addr];
    end
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_hdr_r    <= hdr_nxt;
      out_rx_r     <= (s1_act_r == ACT_READ && in_range && cur.pend) ? cx : '0;
      out_ry_r     <= (s1_act_r == ACT_READ && in_range && cur.pend) ? cy : '0;
      out_pend_r   <= pend_nxt;
      out_chg_r    <= chg_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_chg_r, out_pend_r, out_ry_r, out_rx_r, out_hdr_r};

endmodule
